// ----- rtl/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types, constants and table builders of the wavetable synthesizer.
// ----------------------------------------------------------------------------
package pws_pkg;

  localparam int VOICES      = 16;
  localparam int TABLE_LEN   = 256;
  localparam int FS_HZ       = 48000;
  localparam int WAVES       = 4;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int LVL_W  = 25;
  localparam int KEY_W  = 7;
  localparam int SMP_W  = 16;
  localparam int ACC_W  = $clog2(VOICES * 32000 + 1) + 1;
  localparam int AM_W   = ACC_W;

  localparam logic [LVL_W-1:0] ENV_ONE = 25'h1000000;

  localparam logic [LVL_W-1:0] RST_ATTACK  = 25'd34952;
  localparam logic [LVL_W-1:0] RST_DECAY   = 25'd2097;
  localparam logic [LVL_W-1:0] RST_SUSTAIN = 25'd11744051;
  localparam logic [LVL_W-1:0] RST_RELEASE = 25'd2446;

  localparam logic [22:0] DIV127_M  = 23'd4227330;
  localparam int          DIV127_SH = 29;

  localparam int DIV3_SH = AM_W + 2;
  localparam logic [DIV3_SH-1:0] DIV3_M = DIV3_SH'((64'd1 << DIV3_SH) / 3);

  localparam int SMP_MAX = 32767;
  localparam int SMP_MIN = -32768;

  localparam logic [63:0] ROT_COS_Q30 = 64'd1073418433;
  localparam logic [63:0] ROT_SIN_Q30 = 64'd26350943;
  localparam logic [63:0] SEMI_Q30    = 64'd1137589835;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_TRI    = 2'd2;
  localparam logic [1:0] WAVE_SAW    = 2'd3;

  typedef enum logic [2:0] {
    ST_OFF, ST_ATTACK, ST_DECAY, ST_SUSTAIN, ST_RELEASE
  } stage_t;

  typedef enum logic [1:0] {
    OP_TICK, OP_NOTE_ON, OP_NOTE_OFF, OP_ALL_OFF
  } op_t;

  typedef enum logic [2:0] {
    CFG_ENABLE, CFG_WAVE, CFG_ATTACK, CFG_DECAY, CFG_SUSTAIN, CFG_RELEASE
  } cfg_idx_t;

  typedef enum logic [2:0] {
    K_TICK, K_QUIET, K_NOTE_ON, K_RELEASE, K_ALL_OFF
  } kind_t;

  typedef struct packed {
    logic accept;
    logic release_key;
    logic all_off;
    logic tick_issue;
    logic pick_step;
    logic pick_commit;
    logic mix1;
    logic result_load;
    logic result_zero;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  scan_last;
    logic  pipe_busy;
  } dp_sts_t;

  typedef logic signed [SMP_W-1:0] sine_tab_t [TABLE_LEN];
  typedef logic [31:0] pitch_tab_t [128];

  function automatic sine_tab_t build_sine();
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] cn;
    logic [63:0] sn;
    logic [63:0] m;
    logic [31:0] q [65];
    logic        neg;
    sine_tab_t   t;
    c = 64'd1 << 30;
    s = '0;
    for (int i = 0; i <= 32; i++) begin
      q[i]      = s[31:0];
      q[64 - i] = c[31:0];
      cn = (c * ROT_COS_Q30 - s * ROT_SIN_Q30) >> 30;
      sn = (s * ROT_COS_Q30 + c * ROT_SIN_Q30) >> 30;
      c  = cn;
      s  = sn;
    end
    for (int i = 0; i < TABLE_LEN; i++) begin
      neg = 1'b0;
      if (i <= 64) begin
        m = (64'd16000 * 64'(q[i])) >> 30;
      end else if (i <= 128) begin
        m = (64'd16000 * 64'(q[128 - i])) >> 30;
      end else if (i <= 192) begin
        m = (64'd16000 * 64'(q[i - 128])) >> 30;
        neg = 1'b1;
      end else begin
        m = (64'd16000 * 64'(q[256 - i])) >> 30;
        neg = 1'b1;
      end
      t[i] = neg ? -$signed(m[SMP_W-1:0]) : $signed(m[SMP_W-1:0]);
    end
    return t;
  endfunction

  function automatic pitch_tab_t build_pitch();
    logic [63:0] semis [12];
    logic [63:0] t;
    pitch_tab_t  p;
    int          d;
    int          oct;
    int          semi;
    semis[0] = 64'd1 << 30;
    for (int i = 1; i < 12; i++) semis[i] = (semis[i - 1] * SEMI_Q30) >> 30;
    for (int i = 0; i < 128; i++) begin
      d    = i + 3;
      oct  = d / 12;
      semi = d % 12;
      t = ((64'd440 << 24) * (semis[semi] >> 2)) / 64'(FS_HZ);
      if (oct >= 6) t = (t << (oct - 6)) >> 28;
      else t = t >> (28 + 6 - oct);
      p[i] = t[31:0];
    end
    return p;
  endfunction

  localparam sine_tab_t  SINE_TAB  = build_sine();
  localparam pitch_tab_t PITCH_TAB = build_pitch();

  function automatic logic signed [SMP_W-1:0] wave_sample(input logic [1:0] sel,
                                                          input logic [7:0] idx);
    int i;
    int v;
    i = int'(idx);
    case (sel)
      WAVE_SINE:   v = int'(SINE_TAB[idx]);
      WAVE_SQUARE: v = (i < 128) ? 12000 : -12000;
      WAVE_TRI:    v = (i < 128) ? (250 * i - 16000) : (48000 - 250 * i);
      WAVE_SAW:    v = 125 * i - 16000;
      default:     v = 0;
    endcase
    return SMP_W'(v);
  endfunction

endpackage

// ----- rtl/polyphonic_wavetable_synth.sv -----
// A sample tick runs the one-voice-a-cycle envelope scan, drains the four-stage scaling
// pipeline, then does the mix divide and the result load before the next accept.
// A note-on runs the voice pick scan; note-off, all-off and a tick while disabled
// go straight to the result load.
// One beat at a time; the next beat is taken while a result waits at the output.
// Synchronous active-low reset clears all voices and loads the register defaults.
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth
// Sixteen-voice wavetable synthesizer with ADSR envelopes and a clamped mix.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_synth (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] note_number, [13:7] note_velocity
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] audio_sample, [16] any_voice_active
);
  import pws_pkg::*;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic signed [SMP_W-1:0] sample;
  logic                    any;

  pws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pws_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (in_tuser),
    .in_key     (in_tdata[6:0]),
    .in_vel     (in_tdata[13:7]),
    .cmd        (cmd),
    .sts        (sts),
    .out_sample (sample),
    .out_any    (any)
  );

  assign out_tdata = {7'b0, any, sample};

endmodule

// ----- rtl/pws_dp.sv -----
// ----------------------------------------------------------------------------
// pws_dp
// Voice state, envelope update, scaling pipeline, voice pick scan and mixer.
// ----------------------------------------------------------------------------
module pws_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [24:0]              cfg_data,
  input  logic [1:0]               in_op,
  input  logic [6:0]               in_key,
  input  logic [6:0]               in_vel,
  input  pws_pkg::dp_cmd_t         cmd,
  output pws_pkg::dp_sts_t         sts,
  output logic signed [15:0]       out_sample,
  output logic                     out_any
);
  import pws_pkg::*;

  logic             en_r;
  logic [1:0]       wsel_r;
  logic [LVL_W-1:0] atk_r, dec_r, sus_r, rel_r;

  logic [KEY_W-1:0] key_r, vel_r;

  logic             v_on_r  [VOICES];
  logic [KEY_W-1:0] v_key_r [VOICES];
  logic [KEY_W-1:0] v_vel_r [VOICES];
  logic [31:0]      v_ph_r  [VOICES];
  logic [31:0]      v_stp_r [VOICES];
  logic [LVL_W-1:0] v_lvl_r [VOICES];
  stage_t           v_st_r  [VOICES];
  logic [31:0]      v_age_r [VOICES];
  logic [31:0]      age_ctr_r;

  logic [VIDX_W-1:0] idx_r;

  kind_t            kind_c;

  logic             e_on, e_snd;
  logic [LVL_W-1:0] e_lvl;
  stage_t           e_st;
  logic [LVL_W:0]   atk_sum, dec_lim;

  logic                    s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic signed [SMP_W-1:0] s1_raw_r;
  logic [LVL_W-1:0]        s1_lvl_r;
  logic [KEY_W-1:0]        s1_vel_r, s2_vel_r;
  logic signed [41:0]      s2_prod_r;
  logic signed [49:0]      s3_prod_r;
  logic [49:0]             s3_mag;
  logic [21:0]             s3_a;
  logic [44:0]             s3_mul;
  logic [21:0]             s4_a_r;
  logic [15:0]             s4_q_r;
  logic                    s4_neg_r;
  logic [21:0]             s4_r;
  logic [15:0]             s4_qc;
  logic signed [ACC_W-1:0] s4_val;

  logic signed [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0]        cnt_r;

  logic [AM_W-1:0]         m_am;
  logic [AM_W+DIV3_SH-1:0] m_prod;
  logic                    m_neg_r;
  logic [AM_W-1:0]         m_am_r, m_q3_r;
  logic [CNT_W-1:0]        m_cnt_r;
  logic [AM_W-1:0]         m_r3, m_q;
  logic signed [AM_W:0]    m_sv;
  logic signed [SMP_W-1:0] m_clamp;

  logic              pm_found_r, pf_found_r;
  logic [VIDX_W-1:0] pm_idx_r, pf_idx_r, pb_idx_r, pick_v;
  logic [31:0]       pb_age_r;

  logic signed [SMP_W-1:0] out_sample_r;
  logic                    out_any_r;
  logic                    any_on;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      wsel_r <= WAVE_SINE;
      atk_r  <= RST_ATTACK;
      dec_r  <= RST_DECAY;
      sus_r  <= RST_SUSTAIN;
      rel_r  <= RST_RELEASE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  en_r   <= cfg_data[0];
        CFG_WAVE:    wsel_r <= cfg_data[1:0];
        CFG_ATTACK:  atk_r  <= cfg_data;
        CFG_DECAY:   dec_r  <= cfg_data;
        CFG_SUSTAIN: sus_r  <= cfg_data;
        CFG_RELEASE: rel_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (op_t'(in_op))
      OP_TICK:     kind_c = en_r ? K_TICK : K_QUIET;
      OP_NOTE_ON:  kind_c = (in_vel == '0) ? K_RELEASE : K_NOTE_ON;
      OP_NOTE_OFF: kind_c = K_RELEASE;
      default:     kind_c = K_ALL_OFF;
    endcase
  end

  assign sts.kind      = kind_c;
  assign sts.scan_last = (idx_r == VIDX_W'(VOICES - 1));
  assign sts.pipe_busy = s1_vld_r | s2_vld_r | s3_vld_r | s4_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_key;
      vel_r <= in_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.tick_issue || cmd.pick_step) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // envelope step of the voice under the scan index
  always_comb begin
    e_on    = v_on_r[idx_r];
    e_lvl   = v_lvl_r[idx_r];
    e_st    = v_st_r[idx_r];
    e_snd   = 1'b0;
    atk_sum = {1'b0, v_lvl_r[idx_r]} + {1'b0, atk_r};
    dec_lim = {1'b0, sus_r} + {1'b0, dec_r};
    if (v_on_r[idx_r]) begin
      case (v_st_r[idx_r])
        ST_ATTACK: begin
          e_snd = 1'b1;
          if (atk_sum >= {1'b0, ENV_ONE}) begin
            e_lvl = ENV_ONE;
            e_st  = ST_DECAY;
          end else begin
            e_lvl = atk_sum[LVL_W-1:0];
          end
        end
        ST_DECAY: begin
          e_snd = 1'b1;
          if ({1'b0, v_lvl_r[idx_r]} <= dec_lim) begin
            e_lvl = sus_r;
            e_st  = ST_SUSTAIN;
          end else begin
            e_lvl = v_lvl_r[idx_r] - dec_r;
          end
        end
        ST_SUSTAIN: e_snd = 1'b1;
        ST_RELEASE: begin
          if (v_lvl_r[idx_r] <= rel_r) begin
            e_lvl = '0;
            e_on  = 1'b0;
            e_st  = ST_OFF;
          end else begin
            e_lvl = v_lvl_r[idx_r] - rel_r;
            e_snd = 1'b1;
          end
        end
        default: e_on = 1'b0;
      endcase
    end
  end

  assign pick_v = pm_found_r ? pm_idx_r : (pf_found_r ? pf_idx_r : pb_idx_r);

  // voice store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        v_on_r[i] <= 1'b0;
        v_st_r[i] <= ST_OFF;
      end
      age_ctr_r <= '0;
    end else begin
      if (cmd.all_off) begin
        for (int i = 0; i < VOICES; i++) begin
          v_on_r[i]  <= 1'b0;
          v_st_r[i]  <= ST_OFF;
          v_lvl_r[i] <= '0;
        end
      end
      if (cmd.release_key) begin
        for (int i = 0; i < VOICES; i++) begin
          if (v_on_r[i] && v_key_r[i] == in_key && v_st_r[i] != ST_RELEASE)
            v_st_r[i] <= ST_RELEASE;
        end
      end
      if (cmd.tick_issue) begin
        v_on_r[idx_r]  <= e_on;
        v_lvl_r[idx_r] <= e_lvl;
        v_st_r[idx_r]  <= e_st;
        if (e_snd) v_ph_r[idx_r] <= v_ph_r[idx_r] + v_stp_r[idx_r];
      end
      if (cmd.pick_commit) begin
        v_on_r[pick_v]  <= 1'b1;
        v_key_r[pick_v] <= key_r;
        v_vel_r[pick_v] <= vel_r;
        v_ph_r[pick_v]  <= '0;
        v_stp_r[pick_v] <= PITCH_TAB[key_r];
        v_lvl_r[pick_v] <= '0;
        v_st_r[pick_v]  <= ST_ATTACK;
        v_age_r[pick_v] <= age_ctr_r;
        age_ctr_r       <= age_ctr_r + 32'd1;
      end
    end
  end

  // voice pick scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pm_found_r <= 1'b0;
      pf_found_r <= 1'b0;
      pm_idx_r   <= '0;
      pf_idx_r   <= '0;
      pb_idx_r   <= '0;
      pb_age_r   <= '1;
    end else if (cmd.pick_step) begin
      if (v_on_r[idx_r] && v_key_r[idx_r] == key_r && !pm_found_r) begin
        pm_found_r <= 1'b1;
        pm_idx_r   <= idx_r;
      end
      if (!v_on_r[idx_r] && !pf_found_r) begin
        pf_found_r <= 1'b1;
        pf_idx_r   <= idx_r;
      end
      if (v_age_r[idx_r] < pb_age_r) begin
        pb_age_r <= v_age_r[idx_r];
        pb_idx_r <= idx_r;
      end
    end
  end

  // scaling pipeline
  assign s3_mag = s3_prod_r[49] ? 50'(-s3_prod_r) : 50'(s3_prod_r);
  assign s3_a   = s3_mag[45:24];
  assign s3_mul = {23'b0, s3_a} * {22'b0, DIV127_M};
  assign s4_r   = s4_a_r - 22'(s4_q_r) * 22'd127;
  assign s4_qc  = (s4_r >= 22'd127) ? s4_q_r + 16'd1 : s4_q_r;
  assign s4_val = s4_neg_r ? -ACC_W'($signed({1'b0, s4_qc}))
                           : ACC_W'($signed({1'b0, s4_qc}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.tick_issue & e_snd;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_raw_r  <= wave_sample(wsel_r, v_ph_r[idx_r][23:16]);
    s1_lvl_r  <= e_lvl;
    s1_vel_r  <= v_vel_r[idx_r];
    s2_prod_r <= $signed(s1_raw_r) * $signed({1'b0, s1_lvl_r});
    s2_vel_r  <= s1_vel_r;
    s3_prod_r <= s2_prod_r * $signed({1'b0, s2_vel_r});
    s4_a_r    <= s3_a;
    s4_q_r    <= s3_mul[44:DIV127_SH];
    s4_neg_r  <= s3_prod_r[49];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (cmd.accept) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (s4_vld_r) begin
      acc_r <= acc_r + s4_val;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // mix divide and clamp
  assign m_am   = acc_r[ACC_W-1] ? AM_W'(-acc_r) : AM_W'(acc_r);
  assign m_prod = {{DIV3_SH{1'b0}}, m_am} * {{AM_W{1'b0}}, DIV3_M};

  always_ff @(posedge clk) begin
    if (cmd.mix1) begin
      m_neg_r <= acc_r[ACC_W-1];
      m_am_r  <= m_am;
      m_q3_r  <= m_prod[AM_W+DIV3_SH-1:DIV3_SH];
      m_cnt_r <= cnt_r;
    end
  end

  assign m_r3 = m_am_r - m_q3_r * AM_W'(3);

  always_comb begin
    if (m_cnt_r <= CNT_W'(1))      m_q = m_am_r;
    else if (m_cnt_r == CNT_W'(2)) m_q = m_am_r >> 1;
    else if (m_cnt_r == CNT_W'(3)) m_q = (m_r3 >= AM_W'(3)) ? m_q3_r + 1'b1 : m_q3_r;
    else                           m_q = m_am_r >> 2;
    m_sv = m_neg_r ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});
    if (m_sv > SMP_MAX)      m_clamp = SMP_W'(SMP_MAX);
    else if (m_sv < SMP_MIN) m_clamp = SMP_W'(SMP_MIN);
    else                     m_clamp = m_sv[SMP_W-1:0];
  end

  always_comb begin
    any_on = 1'b0;
    for (int i = 0; i < VOICES; i++) any_on = any_on | v_on_r[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_sample_r <= cmd.result_zero ? '0 : m_clamp;
      out_any_r    <= any_on;
    end
  end

  assign out_sample = out_sample_r;
  assign out_any    = out_any_r;

endmodule

// ----- rtl/pws_ctrl.sv -----
// ----------------------------------------------------------------------------
// pws_ctrl
// Sequencer: accepts a beat, runs the voice scan or pick, loads the result.
// ----------------------------------------------------------------------------
module pws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pws_pkg::dp_sts_t  sts,
  output pws_pkg::dp_cmd_t  cmd
);
  import pws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_DRAIN, S_MIX, S_PICK, S_COMMIT, S_RESULT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   res_zero_r;
  logic   accept;
  logic   load_ok;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign load_ok   = !out_valid_r || out_tready;

  always_comb begin
    cmd.accept      = accept;
    cmd.release_key = accept && (sts.kind == K_RELEASE);
    cmd.all_off     = accept && (sts.kind == K_ALL_OFF);
    cmd.tick_issue  = (state_r == S_TICK);
    cmd.pick_step   = (state_r == S_PICK);
    cmd.pick_commit = (state_r == S_COMMIT);
    cmd.mix1        = (state_r == S_MIX);
    cmd.result_load = (state_r == S_RESULT) && load_ok;
    cmd.result_zero = res_zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      res_zero_r  <= 1'b1;
    end else begin
      if (cmd.result_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (sts.kind)
              K_TICK: begin
                state_r    <= S_TICK;
                res_zero_r <= 1'b0;
              end
              K_NOTE_ON: begin
                state_r    <= S_PICK;
                res_zero_r <= 1'b1;
              end
              default: begin
                state_r    <= S_RESULT;
                res_zero_r <= 1'b1;
              end
            endcase
          end
        end
        S_TICK:   if (sts.scan_last) state_r <= S_DRAIN;
        S_DRAIN:  if (!sts.pipe_busy) state_r <= S_MIX;
        S_MIX:    state_r <= S_RESULT;
        S_PICK:   if (sts.scan_last) state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_RESULT;
        S_RESULT: if (load_ok) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/pws_checker.sv -----
// ----------------------------------------------------------------------------
// pws_checker
// Port-level checks of the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
module pws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  a_sound_needs_voice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] != 16'd0 |-> out_tdata[16])
    else $error("nonzero sample with no active voice");

endmodule

bind polyphonic_wavetable_synth pws_checker u_pws_checker (.*);
